// ----- rtl/core/sstc_pkg.sv -----
// Shared types, codes and digit helpers for the serial-set time-of-day clock.
`timescale 1ns / 1ps
`default_nettype none

package sstc_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register word select (paddr[2]) of the one configuration register
  localparam logic REG_TICKS = 1'b0;

  localparam logic [15:0] RESET_TICKS = 16'd4020;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_RX     = 2'd1;
  localparam logic [1:0] CMD_TXDONE = 2'd2;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] CHR_QUERY  = 8'h74;
  localparam logic [7:0] CHR_SET    = 8'h73;

  localparam logic [7:0] SEC_LIMIT  = 8'd60;
  localparam logic [7:0] MIN_LIMIT  = 8'd60;
  localparam logic [7:0] HOUR_LIMIT = 8'd24;

  typedef logic [8:0][7:0] frame_t;
  typedef logic [7:0][7:0] cap_frame_t;

  // "00:00:00\n", entry 0 first
  localparam frame_t INIT_FRAME = {8'h0A, 8'h30, 8'h30, 8'h3A, 8'h30,
                                   8'h30, 8'h3A, 8'h30, 8'h30};

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       led;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } sstc_res_t;

  // Tens and units characters of v: {tens, units}, quotient by 205/2048
  function automatic logic [15:0] digit_pair(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  q;
    logic [7:0]  r;
    prod = 16'(v) * 16'd205;
    q    = {3'b000, prod[15:11]};
    r    = v - ((q << 3) + (q << 1));
    return {q + ASCII_ZERO, r + ASCII_ZERO};
  endfunction

  // Two ASCII digits to a value, 8-bit wrap, no checking
  function automatic logic [7:0] digits_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] a;
    logic [7:0] b;
    a = hi - ASCII_ZERO;
    b = lo - ASCII_ZERO;
    return (a << 3) + (a << 1) + b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sstc_if.sv -----
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface sstc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface sstc_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       led;
  logic [7:0] hours;
  logic [7:0] minutes;
  logic [7:0] seconds;

  modport source (output valid, output tx_valid, output tx_byte, output led,
                  output hours, output minutes, output seconds, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input led,
                input hours, input minutes, input seconds, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sstc_core.sv -----
// Clock state, text frames and the per-word update logic.
`timescale 1ns / 1ps
`default_nettype none

module sstc_core import sstc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] ticks,
  output sstc_res_t        res
);

  logic [15:0] pre_r,  pre_nxt;
  logic [7:0]  sec_r,  sec_nxt;
  logic [7:0]  min_r,  min_nxt;
  logic [7:0]  hour_r, hour_nxt;
  frame_t      sf_r,   sf_nxt;
  cap_frame_t  cf_r,   cf_nxt;
  logic        sending_r, sending_nxt;
  logic        capturing_r, capturing_nxt;
  logic [3:0]  sp_r,   sp_nxt;
  logic [3:0]  cp_r,   cp_nxt;
  logic        led_r,  led_nxt;

  logic [15:0] pre_inc;
  logic [7:0]  sec_inc;
  logic [7:0]  min_inc;
  logic [7:0]  hour_inc;
  logic [3:0]  cp_inc;
  logic [3:0]  sp_use;
  logic [3:0]  sp_inc;
  logic [15:0] hp;
  logic [15:0] mp;
  logic [15:0] spair;
  logic        emit;
  logic [7:0]  ch;

  always_comb begin
    pre_nxt       = pre_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    sf_nxt        = sf_r;
    cf_nxt        = cf_r;
    sending_nxt   = sending_r;
    capturing_nxt = capturing_r;
    sp_nxt        = sp_r;
    cp_nxt        = cp_r;
    led_nxt       = led_r;
    emit          = 1'b0;
    ch            = 8'd0;
    pre_inc       = pre_r + 16'd1;
    sec_inc       = sec_r + 8'd1;
    min_inc       = min_r + 8'd1;
    hour_inc      = hour_r + 8'd1;
    cp_inc        = cp_r + 4'd1;
    sp_use        = (sp_r < 4'd1 || sp_r > 4'd8) ? 4'd1 : sp_r;
    sp_inc        = sp_use + 4'd1;
    hp            = 16'd0;
    mp            = 16'd0;
    spair         = 16'd0;

    case (cmd)
      CMD_TICK: begin
        led_nxt = ~led_r;
        if (pre_inc != ticks) begin
          pre_nxt = pre_inc;
        end else begin
          pre_nxt = 16'd0;
          sec_nxt = sec_inc;
          if (sec_inc == SEC_LIMIT) begin
            sec_nxt = 8'd0;
            min_nxt = min_inc;
            if (min_inc == MIN_LIMIT) begin
              min_nxt  = 8'd0;
              hour_nxt = (hour_inc == HOUR_LIMIT) ? 8'd0 : hour_inc;
              hp        = digit_pair(hour_nxt);
              sf_nxt[0] = hp[15:8];
              sf_nxt[1] = hp[7:0];
            end
            mp        = digit_pair(min_nxt);
            sf_nxt[3] = mp[15:8];
            sf_nxt[4] = mp[7:0];
          end
          spair     = digit_pair(sec_nxt);
          sf_nxt[6] = spair[15:8];
          sf_nxt[7] = spair[7:0];
        end
      end
      CMD_RX: begin
        if (capturing_r) begin
          cf_nxt[cp_r[2:0]] = rx_byte;
          cp_nxt = cp_inc;
          if (cp_inc == 4'd8) begin
            sec_nxt       = digits_value(cf_nxt[6], cf_nxt[7]);
            min_nxt       = digits_value(cf_nxt[3], cf_nxt[4]);
            hour_nxt      = digits_value(cf_nxt[0], cf_nxt[1]);
            sf_nxt[0]     = cf_nxt[0];
            sf_nxt[1]     = cf_nxt[1];
            sf_nxt[3]     = cf_nxt[3];
            sf_nxt[4]     = cf_nxt[4];
            sf_nxt[6]     = cf_nxt[6];
            sf_nxt[7]     = cf_nxt[7];
            sending_nxt   = 1'b1;
            cp_nxt        = 4'd0;
            capturing_nxt = 1'b0;
            emit          = 1'b1;
          end
        end
        if (rx_byte == CHR_QUERY) begin
          sending_nxt = 1'b1;
          emit        = 1'b1;
        end
        if (rx_byte == CHR_SET) begin
          capturing_nxt = 1'b1;
        end
        if (emit) begin
          ch = sf_nxt[0];
        end
      end
      CMD_TXDONE: begin
        if (sending_r) begin
          emit = 1'b1;
          ch   = sf_r[sp_use];
          if (sp_inc == 4'd9) begin
            sp_nxt      = 4'd1;
            sending_nxt = 1'b0;
          end else begin
            sp_nxt = sp_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r       <= 16'd0;
      sec_r       <= 8'd0;
      min_r       <= 8'd0;
      hour_r      <= 8'd0;
      sf_r        <= INIT_FRAME;
      cf_r        <= INIT_FRAME[7:0];
      sending_r   <= 1'b0;
      capturing_r <= 1'b0;
      sp_r        <= 4'd1;
      cp_r        <= 4'd0;
      led_r       <= 1'b0;
    end else if (step) begin
      pre_r       <= pre_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      sf_r        <= sf_nxt;
      cf_r        <= cf_nxt;
      sending_r   <= sending_nxt;
      capturing_r <= capturing_nxt;
      sp_r        <= sp_nxt;
      cp_r        <= cp_nxt;
      led_r       <= led_nxt;
    end
  end

  always_comb begin
    res.tx_valid = emit;
    res.tx_byte  = ch;
    res.led      = led_nxt;
    res.hours    = hour_nxt;
    res.minutes  = min_nxt;
    res.seconds  = sec_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/serial_set_time_of_day_clock.sv -----
// Serial-set time-of-day clock: top level with channels and register port.
//
// Input channel in_ch carries one command word per handshake: cmd 0 is a
// timer tick, 1 a received character (rx_byte), 2 a transmit-complete event.
// Output channel out_ch returns exactly one result word per command word:
// tx_valid/tx_byte for the character to send now, the LED level and the
// hours/minutes/seconds counters after the command.
// A command word is captured in an input register and, once the result
// register is free, processed by sstc_core into the result register; one
// word per cycle is sustained while out_ch is ready, and sstc_core updates
// the clock counters and frame combinationally for each word.
// When out_ch stalls, the result register holds and one more word may sit in
// the input register; in_ch.ready drops only when both are full.
// The APB register at word 0 (ticks_per_second, 16 bits) sets how many ticks
// make one second; write it only while no word is in flight.
// Synchronous reset clears the time to 00:00:00, the LED to low, stops any
// send or capture, and loads ticks_per_second with 4020.
`timescale 1ns / 1ps
`default_nettype none

module serial_set_time_of_day_clock import sstc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sstc_in_if.sink                in_ch,
  sstc_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  logic [15:0] ticks_r;
  logic        s1_valid_r;
  logic [1:0]  s1_cmd_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  sstc_res_t   out_r;
  sstc_res_t   res;
  logic        adv;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TICKS);
  assign prdata = (paddr[2] == REG_TICKS) ? {16'd0, ticks_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= RESET_TICKS;
    end else if (cfg_wr) begin
      ticks_r <= pwdata[15:0];
    end
  end

  // Advance the held word into the result register when that slot frees up
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  sstc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .cmd     (s1_cmd_r),
    .rx_byte (s1_byte_r),
    .ticks   (ticks_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tx_valid = out_r.tx_valid;
  assign out_ch.tx_byte  = out_r.tx_byte;
  assign out_ch.led      = out_r.led;
  assign out_ch.hours    = out_r.hours;
  assign out_ch.minutes  = out_r.minutes;
  assign out_ch.seconds  = out_r.seconds;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the serial-set time-of-day clock.
`timescale 1ns / 1ps

module testbench;
  import sstc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 150;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [15:0] PHASE_PERIODS [0:8] = '{16'd1, 16'd3, 16'd2, 16'd65535, 16'd1,
                                                  16'd5, 16'd2, 16'd7, 16'd1};

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } cmd_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  logic drive_valid = 1'b0;
  logic [1:0] drive_cmd = CMD_TICK;
  logic [7:0] drive_byte = 8'h00;
  logic take_ready = 1'b0;

  sstc_in_if in_ch();
  sstc_out_if out_ch();

  assign in_ch.valid = drive_valid;
  assign in_ch.cmd = drive_cmd;
  assign in_ch.rx_byte = drive_byte;
  assign out_ch.ready = take_ready;

  serial_set_time_of_day_clock dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  cmd_word_t pending_words[$];
  sstc_res_t expected_results[$];
  int fail_count = 0;
  int idle_max = 17;
  int results_seen = 0;
  int words_queued = 0;
  int send_gap = 0;
  int recv_wait = 0;

  // Predicted clock state
  logic [15:0] tick_period = RESET_TICKS;
  logic [15:0] prescale = '0;
  logic [7:0] secs = '0;
  logic [7:0] mins = '0;
  logic [7:0] hrs = '0;
  frame_t text_frame = INIT_FRAME;
  cap_frame_t set_text = INIT_FRAME[7:0];
  logic sending_on = 1'b0;
  logic capture_armed = 1'b0;
  logic [3:0] send_idx = 4'd1;
  logic [3:0] cap_idx = 4'd0;
  logic led_q = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // {tens, units} as ASCII, 8-bit wrap
  function automatic logic [15:0] ascii_digits(input logic [7:0] v);
    logic [7:0] t;
    logic [7:0] u;
    t = v / 8'd10 + ASCII_ZERO;
    u = v % 8'd10 + ASCII_ZERO;
    return {t, u};
  endfunction

  function automatic logic [7:0] chars_to_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] a;
    logic [7:0] b;
    a = hi - ASCII_ZERO;
    b = lo - ASCII_ZERO;
    return a * 8'd10 + b;
  endfunction

  function automatic sstc_res_t clock_predict(input cmd_word_t w);
    sstc_res_t r;
    logic emit;
    logic [15:0] pair;
    r = '0;
    emit = 1'b0;
    case (w.cmd)
      CMD_TICK: begin
        led_q = ~led_q;
        prescale = prescale + 16'd1;
        if (prescale == tick_period) begin
          prescale = '0;
          secs = secs + 8'd1;
          if (secs == SEC_LIMIT) begin
            secs = '0;
            mins = mins + 8'd1;
            if (mins == MIN_LIMIT) begin
              mins = '0;
              hrs = hrs + 8'd1;
              if (hrs == HOUR_LIMIT) hrs = '0;
              pair = ascii_digits(hrs);
              text_frame[0] = pair[15:8];
              text_frame[1] = pair[7:0];
            end
            pair = ascii_digits(mins);
            text_frame[3] = pair[15:8];
            text_frame[4] = pair[7:0];
          end
          pair = ascii_digits(secs);
          text_frame[6] = pair[15:8];
          text_frame[7] = pair[7:0];
        end
      end
      CMD_RX: begin
        if (capture_armed) begin
          set_text[cap_idx[2:0]] = w.rx_byte;
          cap_idx = cap_idx + 4'd1;
          if (cap_idx == 4'd8) begin
            secs = chars_to_value(set_text[6], set_text[7]);
            mins = chars_to_value(set_text[3], set_text[4]);
            hrs = chars_to_value(set_text[0], set_text[1]);
            // colons stay as they are
            for (int i = 0; i < 8; i++) begin
              if (i != 2 && i != 5) text_frame[i] = set_text[i];
            end
            sending_on = 1'b1;
            cap_idx = '0;
            capture_armed = 1'b0;
            emit = 1'b1;
          end
        end
        if (w.rx_byte == CHR_QUERY) begin
          sending_on = 1'b1;
          emit = 1'b1;
        end
        if (w.rx_byte == CHR_SET) capture_armed = 1'b1;
        if (emit) begin
          r.tx_valid = 1'b1;
          r.tx_byte = text_frame[0];
        end
      end
      CMD_TXDONE: begin
        if (sending_on) begin
          if (send_idx < 4'd1 || send_idx > 4'd8) send_idx = 4'd1;
          r.tx_valid = 1'b1;
          r.tx_byte = text_frame[send_idx];
          send_idx = send_idx + 4'd1;
          if (send_idx == 4'd9) begin
            send_idx = 4'd1;
            sending_on = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    r.led = led_q;
    r.hours = hrs;
    r.minutes = mins;
    r.seconds = secs;
    return r;
  endfunction

  function automatic void push_word(input logic [1:0] cmd, input logic [7:0] b);
    cmd_word_t w;
    w.cmd = cmd;
    w.rx_byte = b;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  function automatic void push_set_time(input logic [7:0] hh, input logic [7:0] mm,
                                        input logic [7:0] ss);
    logic [15:0] h2;
    logic [15:0] m2;
    logic [15:0] s2;
    h2 = ascii_digits(hh);
    m2 = ascii_digits(mm);
    s2 = ascii_digits(ss);
    push_word(CMD_RX, CHR_SET);
    push_word(CMD_RX, h2[15:8]);
    push_word(CMD_RX, h2[7:0]);
    push_word(CMD_RX, CHR_COLON);
    push_word(CMD_RX, m2[15:8]);
    push_word(CMD_RX, m2[7:0]);
    push_word(CMD_RX, CHR_COLON);
    push_word(CMD_RX, s2[15:8]);
    push_word(CMD_RX, s2[7:0]);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Hold until every queued word is accepted and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || drive_valid || expected_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_ticks(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TICKS, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tick_period = value;
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== value) begin
      $error("ticks_per_second mismatch: expected %0d, actual %0d", value, prdata[15:0]);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : driver
    logic offer;
    cmd_word_t w;
    if (!rst_n) begin
      drive_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = drive_valid;
      if (in_ch.valid && in_ch.ready) begin
        w.cmd = in_ch.cmd;
        w.rx_byte = in_ch.rx_byte;
        expected_results.push_back(clock_predict(w));
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          drive_cmd <= w.cmd;
          drive_byte <= w.rx_byte;
          offer = 1'b1;
          send_gap = $urandom_range(0, idle_max);
        end
      end
      drive_valid <= offer;
    end
  end

  always @(posedge clk) begin : monitor
    sstc_res_t want;
    if (!rst_n) begin
      take_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word: tx_valid %0d tx_byte %0d",
                 out_ch.tx_valid, out_ch.tx_byte);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, out_ch.tx_valid});
          check_field("tx_byte", want.tx_byte, out_ch.tx_byte);
          check_field("led", {7'd0, want.led}, {7'd0, out_ch.led});
          check_field("hours", want.hours, out_ch.hours);
          check_field("minutes", want.minutes, out_ch.minutes);
          check_field("seconds", want.seconds, out_ch.seconds);
        end
        recv_wait = $urandom_range(0, idle_max);
        // stall long enough for the input side to back up
        if (idle_max > 0 && results_seen % 400 == 200) recv_wait = LONG_HOLD;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      take_ready <= (recv_wait == 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int pick;
    int stop_at;
    int k;
    logic [7:0] hh;
    logic [7:0] mm;
    logic [7:0] ss;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle commands, send with restart, set to the last second of the day
    push_word(CMD_TICK, 8'h00);
    push_word(CMD_TICK, 8'hFF);
    push_word(CMD_UNUSED, 8'hFF);
    push_word(CMD_TXDONE, 8'h00);
    push_word(CMD_RX, 8'hFF);
    push_word(CMD_RX, CHR_QUERY);
    repeat (3) push_word(CMD_TXDONE, 8'h00);
    push_word(CMD_RX, CHR_QUERY);
    repeat (6) push_word(CMD_TXDONE, 8'hFF);
    push_set_time(8'd23, 8'd59, 8'd59);
    wait_idle();

    // Change the period mid-count, drop it below the running count, then zero it
    write_ticks(16'd8);
    repeat (3) push_word(CMD_TICK, 8'h00);
    wait_idle();
    write_ticks(16'd3);
    repeat (10) push_word(CMD_TICK, 8'h00);
    wait_idle();
    write_ticks(16'd0);
    idle_max = 0;
    repeat (10) push_word(CMD_TICK, 8'h00);
    push_word(CMD_RX, CHR_QUERY);
    repeat (8) push_word(CMD_TXDONE, 8'h00);

    for (phase = 0; phase < 9; phase++) begin
      wait_idle();
      // realign the prescaler so the new period counts from zero
      write_ticks(prescale + 16'd1);
      push_word(CMD_TICK, 8'h00);
      wait_idle();
      write_ticks(PHASE_PERIODS[phase]);
      idle_max = (phase % 3 == 2) ? 0 : 17;
      stop_at = words_queued + 195;
      while (words_queued < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          repeat ($urandom_range(1, 12)) push_word(CMD_TICK, 8'($urandom_range(0, 255)));
        end else if (pick < 55) begin
          hh = $urandom_range(0, 1) ? 8'd23 : 8'($urandom_range(0, 23));
          mm = $urandom_range(0, 1) ? 8'd59 : 8'($urandom_range(0, 59));
          ss = $urandom_range(0, 3) ? 8'($urandom_range(55, 59)) : 8'($urandom_range(0, 59));
          if ($urandom_range(0, 9) == 0) begin
            hh = 8'($urandom_range(24, 99));
            mm = 8'($urandom_range(60, 99));
            ss = 8'($urandom_range(60, 99));
          end
          push_set_time(hh, mm, ss);
          repeat ($urandom_range(0, 9)) push_word(CMD_TXDONE, 8'($urandom_range(0, 255)));
        end else if (pick < 75) begin
          push_word(CMD_RX, CHR_QUERY);
          // restart the send partway through
          if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 7);
            repeat (k) push_word(CMD_TXDONE, 8'($urandom_range(0, 255)));
            push_word(CMD_RX, CHR_QUERY);
          end
          repeat (8 + $urandom_range(0, 2)) push_word(CMD_TXDONE, 8'($urandom_range(0, 255)));
        end else if (pick < 87) begin
          push_word(CMD_RX, CHR_SET);
          repeat (7) push_word(CMD_RX, 8'($urandom_range(0, 255)));
          k = $urandom_range(0, 2);
          push_word(CMD_RX, (k == 0) ? CHR_QUERY : (k == 1) ? CHR_SET :
                            8'($urandom_range(0, 255)));
        end else if (pick < 98) begin
          push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end else begin
          wait_idle();
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sstc_pkg.sv
rtl/core/sstc_if.sv
rtl/core/sstc_core.sv
rtl/core/serial_set_time_of_day_clock.sv
tb/testbench.sv
